// ===== src/pic_pkg.sv =====
package pic_pkg;

   // field and datapath widths
   localparam int LuxW     = 18;
   localparam int PgainW   = 16;
   localparam int IpgW     = 20;
   localparam int ErrW     = 19;
   localparam int LastErrW = 20;
   localparam int StateW   = 32;
   localparam int MulAW    = 38;
   localparam int MulBW    = 21;
   localparam int ProdW    = MulAW + MulBW;
   localparam int AccW     = 40;
   localparam int PctW     = 7;
   localparam int DutyW    = 8;
   localparam int ClampW   = 2;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 20;

   // rescale shifts back to q.8
   localparam int PropShift = 8;
   localparam int CmdShift  = 16;

   // register reset values and arithmetic constants
   localparam logic [PgainW-1:0]        PropGainRst = 16'd256;
   localparam logic [IpgW-1:0]          InvGainRst  = 20'd65536;
   localparam logic signed [MulBW-1:0]  AwCoef      = 21'sd6554;
   localparam logic signed [ErrW-1:0]   DeadZone    = 19'sd128;
   localparam logic signed [StateW-1:0] CmdMax      = 32'sd25600;
   localparam logic [DutyW-1:0]         DutyMax     = 8'd255;
   localparam logic [DutyW-1:0]         DutyMin     = 8'd0;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrPropGain    = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrInvPlantGain = 2'd1;

   // clamp status codes
   localparam logic [ClampW-1:0] ClampNone = 2'd0;
   localparam logic [ClampW-1:0] ClampLow  = 2'd1;
   localparam logic [ClampW-1:0] ClampHigh = 2'd2;

   typedef struct packed {
      logic [LuxW-1:0] measured_lux;
      logic [LuxW-1:0] target_lux;
   } req_type;

   typedef struct packed {
      logic [DutyW-1:0]  duty;
      logic [ClampW-1:0] clamp_state;
   } rsp_type;

   // saturate a wide signed value to the 32-bit signed range
   function automatic logic signed [StateW-1:0] sat32(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi;
      logic signed [AccW-1:0] lo;
      hi = {{(AccW-StateW+1){1'b0}}, {(StateW-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[StateW-1:0];
      end else if (v < lo) begin
         return lo[StateW-1:0];
      end else begin
         return v[StateW-1:0];
      end
   endfunction

   // percent 0..100 to byte: pct*255/100 via reciprocal 5243/2^19
   function automatic logic [DutyW-1:0] duty_of(input logic [PctW-1:0] pct);
      logic [14:0] scaled;
      logic [27:0] recip;
      scaled = {pct, 8'd0} - 15'(pct);
      recip  = 28'(scaled) * 28'd5243;
      return recip[26:19];
   endfunction

endpackage

// ===== src/pic_mul.sv =====
module pic_mul (
   input  logic                                 clock,
   input  logic                                 mul_en,
   input  logic signed [pic_pkg::MulAW-1:0]     mul_a,
   input  logic signed [pic_pkg::MulBW-1:0]     mul_b,
   output logic signed [pic_pkg::ProdW-1:0]     prod
);

   logic signed [pic_pkg::ProdW-1:0] prod_ff;

   // shared signed multiplier, product registered
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= pic_pkg::ProdW'(mul_a) * pic_pkg::ProdW'(mul_b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== src/pic_out.sv =====
module pic_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [pic_pkg::StateW-1:0]    cmd,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output pic_pkg::rsp_type                     rsp_data
);

   logic             rsp_valid_ff;
   pic_pkg::rsp_type rsp_data_ff;
   pic_pkg::rsp_type rsp_data_in;

   // clamp to 0..100 percent and map to duty byte
   always_comb begin
      if (cmd < 0) begin
         rsp_data_in.clamp_state = pic_pkg::ClampLow;
         rsp_data_in.duty        = pic_pkg::DutyMin;
      end else if (cmd > pic_pkg::CmdMax) begin
         rsp_data_in.clamp_state = pic_pkg::ClampHigh;
         rsp_data_in.duty        = pic_pkg::DutyMax;
      end else begin
         rsp_data_in.clamp_state = pic_pkg::ClampNone;
         rsp_data_in.duty        = pic_pkg::duty_of(
            cmd[pic_pkg::PropShift+pic_pkg::PctW-1:pic_pkg::PropShift]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/pi_illuminance_controller.sv =====
// PI illuminance controller with anti-windup and feed-forward. Each request is
// one control tick carrying measured and target lux in unsigned Q10.8; it
// yields one response with the PWM duty byte and the clamp status. A new
// request is taken only once the previous one reaches the output register:
// a small sequencer makes four passes through one shared registered multiplier
// (proportional term, command scaling, anti-windup, feed-forward) with add and
// saturate steps between them; a finished response waits in an output register
// so a new request can start while it is pending. The user writes gains through
// the csr port while no request is in flight; the block does not enforce this.
module pi_illuminance_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pic_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pic_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [pic_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [pic_pkg::CsrDataW-1:0]        csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PMUL,
      ST_PI,
      ST_U0MUL,
      ST_AWSUB,
      ST_AWMUL,
      ST_FFMUL,
      ST_SUM,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   // configuration registers
   logic [pic_pkg::PgainW-1:0] prop_gain_ff;
   logic [pic_pkg::IpgW-1:0]   inv_plant_gain_ff;

   // controller state
   logic signed [pic_pkg::StateW-1:0]   integral_ff;
   logic signed [pic_pkg::LastErrW-1:0] last_err_ff;
   logic signed [pic_pkg::StateW-1:0]   last_u_ff;

   // working registers
   logic signed [pic_pkg::ErrW-1:0]   err_ff;
   logic signed [pic_pkg::ErrW-1:0]   err_in;
   logic [pic_pkg::LuxW-1:0]          targ_ff;
   logic signed [pic_pkg::StateW-1:0] i_ff;
   logic signed [pic_pkg::StateW-1:0] i_in;
   logic signed [pic_pkg::AccW-1:0]   sum_ff;
   logic signed [pic_pkg::AccW-1:0]   sum_in;
   logic signed [pic_pkg::AccW-1:0]   u0_ff;
   logic signed [pic_pkg::MulAW-1:0]  diff_ff;
   logic signed [pic_pkg::AccW-1:0]   acc_ff;
   logic signed [pic_pkg::StateW-1:0] u_ff;
   logic signed [pic_pkg::StateW-1:0] u_in;

   logic signed [pic_pkg::AccW-1:0]   isum;
   logic signed [pic_pkg::AccW-1:0]   p_val;
   logic signed [pic_pkg::AccW-1:0]   prod_q8;
   logic                              dead;
   logic signed [pic_pkg::ProdW-1:0]  prod;
   logic signed [pic_pkg::MulAW-1:0]  mul_a;
   logic signed [pic_pkg::MulBW-1:0]  mul_b;
   logic                              mul_en;
   logic                              out_free;
   logic                              out_load;
   logic                              req_accept;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid || rsp_ready;
   assign out_load   = (state_ff == ST_DONE) && out_free;
   assign req_ready  = req_ready_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= pic_pkg::PropGainRst;
         inv_plant_gain_ff <= pic_pkg::InvGainRst;
      end else if (csr_write) begin
         if (csr_index == pic_pkg::CsrPropGain) begin
            prop_gain_ff <= csr_wdata[pic_pkg::PgainW-1:0];
         end else if (csr_index == pic_pkg::CsrInvPlantGain) begin
            inv_plant_gain_ff <= csr_wdata[pic_pkg::IpgW-1:0];
         end
      end
   end

   // error, integral and proportional arithmetic
   assign err_in = pic_pkg::ErrW'($signed({1'b0, req_data.target_lux})
                                  - $signed({1'b0, req_data.measured_lux}));
   assign isum   = pic_pkg::AccW'(integral_ff) + pic_pkg::AccW'(err_ff)
                   + pic_pkg::AccW'(last_err_ff);
   assign i_in   = pic_pkg::sat32(isum);
   assign dead   = (err_ff > -pic_pkg::DeadZone) && (err_ff < pic_pkg::DeadZone);
   assign p_val  = dead ? '0 : pic_pkg::AccW'(prod >>> pic_pkg::PropShift);
   assign sum_in = p_val + pic_pkg::AccW'(i_ff);

   // products rescaled from q.24 back to q.8
   assign prod_q8 = pic_pkg::AccW'(prod >>> pic_pkg::CmdShift);
   assign u_in    = pic_pkg::sat32(acc_ff + prod_q8);

   // multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      case (state_ff)
         ST_PMUL: begin
            mul_a = pic_pkg::MulAW'(err_ff);
            mul_b = pic_pkg::MulBW'($signed({1'b0, prop_gain_ff}));
         end
         ST_U0MUL: begin
            mul_a = pic_pkg::MulAW'(sum_ff);
            mul_b = pic_pkg::MulBW'($signed({1'b0, inv_plant_gain_ff}));
         end
         ST_AWMUL: begin
            mul_a = diff_ff;
            mul_b = pic_pkg::AwCoef;
         end
         ST_FFMUL: begin
            mul_a = pic_pkg::MulAW'($signed({1'b0, targ_ff}));
            mul_b = pic_pkg::MulBW'($signed({1'b0, inv_plant_gain_ff}));
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = '0;
            mul_b  = '0;
         end
      endcase
   end

   pic_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

   // sequencer and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         integral_ff  <= '0;
         last_err_ff  <= '0;
         last_u_ff    <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff     <= ST_PMUL;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_PMUL:  state_ff <= ST_PI;
            ST_PI:    state_ff <= ST_U0MUL;
            ST_U0MUL: state_ff <= ST_AWSUB;
            ST_AWSUB: state_ff <= ST_AWMUL;
            ST_AWMUL: state_ff <= ST_FFMUL;
            ST_FFMUL: state_ff <= ST_SUM;
            ST_SUM: begin
               state_ff    <= ST_DONE;
               integral_ff <= i_ff;
               last_err_ff <= pic_pkg::LastErrW'(err_ff);
               last_u_ff   <= u_in;
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   // working datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         err_ff  <= err_in;
         targ_ff <= req_data.target_lux;
      end
      if (state_ff == ST_PMUL) begin
         i_ff <= i_in;
      end
      if (state_ff == ST_PI) begin
         sum_ff <= sum_in;
      end
      if (state_ff == ST_AWSUB) begin
         u0_ff   <= prod_q8;
         diff_ff <= pic_pkg::MulAW'(prod_q8 - pic_pkg::AccW'(last_u_ff));
      end
      if (state_ff == ST_FFMUL) begin
         acc_ff <= u0_ff + prod_q8;
      end
      if (state_ff == ST_SUM) begin
         u_ff <= u_in;
      end
   end

   pic_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .cmd       (u_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a request keeps the block busy through the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("request accepted while sequencer stays ready");

   // clamp status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.clamp_state == pic_pkg::ClampNone ||
                     rsp_data.clamp_state == pic_pkg::ClampLow ||
                     rsp_data.clamp_state == pic_pkg::ClampHigh))
      else $error("undefined clamp status");

   // clamped responses carry the rail duty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clamp_state == pic_pkg::ClampHigh)
         |-> rsp_data.duty == pic_pkg::DutyMax)
      else $error("high clamp without full duty");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.clamp_state == pic_pkg::ClampLow)
         |-> rsp_data.duty == pic_pkg::DutyMin)
      else $error("low clamp without zero duty");

endmodule
